// ===== rtl/igs_pkg.sv =====
// Shared types and constants for the implicit 2-D diffusion Gauss-Seidel block.
`default_nettype none
package igs_pkg;

    // operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_COEF_X     = 3'd0;
    localparam logic [2:0] REG_COEF_Y     = 3'd1;
    localparam logic [2:0] REG_TOLERANCE  = 3'd2;
    localparam logic [2:0] REG_MAX_SWEEPS = 3'd3;
    localparam logic [2:0] REG_TIME_STEPS = 3'd4;

    localparam logic [30:0] COEF_X_RST     = 31'd40282095;
    localparam logic [30:0] COEF_Y_RST     = 31'd40282095;
    localparam logic [30:0] TOLERANCE_RST  = 31'd17;
    localparam logic [9:0]  MAX_SWEEPS_RST = 10'd1000;
    localparam logic [9:0]  TIME_STEPS_RST = 10'd100;

    // quotient bits produced by the restoring divider
    localparam int DIV_STEPS = 42;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] cell_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [9:0]         sweeps_used;
        logic               converged;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic signed [32:0] sum_x;
        logic signed [32:0] sum_y;
        logic signed [31:0] prev;
    } cell_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } cell_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/igs_cell_unit.sv =====
// Shared multiply and divide unit computing one Gauss-Seidel cell update.
`default_nettype none
module igs_cell_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [30:0]       coef_x,
    input  wire logic [30:0]       coef_y,
    input  wire igs_pkg::cell_req_t req,
    output igs_pkg::cell_rsp_t     rsp
);
    import igs_pkg::*;

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;
    localparam logic [1:0] U_FIN  = 2'd3;

    logic [1:0]         st_reg;
    logic [5:0]         cnt_reg;
    logic [32:0]        mx_reg, my_reg;
    logic               negx_reg, negy_reg;
    logic signed [31:0] prev_reg;
    logic [47:0]        prod_reg;
    logic [62:0]        px_reg, py_reg;
    logic               neg_reg;
    logic [34:0]        rem_reg;
    logic [41:0]        sh_reg;
    logic signed [31:0] val_reg;
    logic               done_reg;

    logic [30:0]        mul_a;
    logic [16:0]        mul_b;
    logic [63:0]        rx, ry;
    logic [39:0]        tx, ty;
    logic signed [41:0] tx_s, ty_s, num, num_abs;
    logic [33:0]        den;
    logic [34:0]        dvsr;
    logic [66:0]        nume;
    logic [35:0]        trial;
    logic               ge;
    logic signed [31:0] sat;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    begin mul_a = coef_x; mul_b = {1'b0, mx_reg[15:0]}; end
            2'd1:    begin mul_a = coef_x; mul_b = mx_reg[32:16]; end
            2'd2:    begin mul_a = coef_y; mul_b = {1'b0, my_reg[15:0]}; end
            default: begin mul_a = coef_y; mul_b = my_reg[32:16]; end
        endcase
    end

    // round products to Q8.24, nearest, ties away from zero (on magnitudes)
    assign rx   = {1'b0, px_reg} + 64'(1 << 23);
    assign ry   = {1'b0, py_reg} + 64'(1 << 23);
    assign tx   = rx[63:24];
    assign ty   = ry[63:24];
    assign tx_s = negx_reg ? -$signed({2'b0, tx}) : $signed({2'b0, tx});
    assign ty_s = negy_reg ? -$signed({2'b0, ty}) : $signed({2'b0, ty});
    assign num  = {{10{prev_reg[31]}}, prev_reg} + tx_s + ty_s;
    assign num_abs = num[41] ? -num : num;

    assign den  = 34'(1 << 24) + {2'b0, coef_x, 1'b0} + {2'b0, coef_y, 1'b0};
    assign dvsr = {den, 1'b0};
    // rounded quotient = floor((m * 2^25 + den) / (2 * den))
    assign nume = {1'b0, num_abs[40:0], 25'b0} + {33'b0, den};

    assign trial = {rem_reg, sh_reg[41]};
    assign ge    = trial >= {1'b0, dvsr};

    always_comb begin
        if (neg_reg) begin
            sat = (sh_reg >= 42'h0_8000_0000) ? 32'sh8000_0000 : -$signed(sh_reg[31:0]);
        end else begin
            sat = (sh_reg > 42'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(sh_reg[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= U_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (st_reg)
                U_IDLE: begin
                    if (req.start) begin
                        mx_reg   <= req.sum_x[32] ? 33'(-req.sum_x) : 33'(req.sum_x);
                        my_reg   <= req.sum_y[32] ? 33'(-req.sum_y) : 33'(req.sum_y);
                        negx_reg <= req.sum_x[32];
                        negy_reg <= req.sum_y[32];
                        prev_reg <= req.prev;
                        cnt_reg  <= '0;
                        st_reg   <= U_MUL;
                    end
                end
                U_MUL: begin
                    prod_reg <= {17'b0, mul_a} * {31'b0, mul_b};
                    case (cnt_reg)
                        6'd1:    px_reg <= 63'(prod_reg);
                        6'd2:    px_reg <= px_reg + 63'({prod_reg, 16'b0});
                        6'd3:    py_reg <= 63'(prod_reg);
                        6'd4:    py_reg <= py_reg + 63'({prod_reg, 16'b0});
                        default: ;
                    endcase
                    if (cnt_reg == 6'd5) begin
                        neg_reg <= num[41];
                        rem_reg <= {10'b0, nume[66:42]};
                        sh_reg  <= nume[41:0];
                        cnt_reg <= '0;
                        st_reg  <= U_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                U_DIV: begin
                    rem_reg <= ge ? 35'(trial - {1'b0, dvsr}) : trial[34:0];
                    sh_reg  <= {sh_reg[40:0], ge};
                    if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                        st_reg <= U_FIN;
                    end else begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                default: begin
                    val_reg  <= sat;
                    done_reg <= 1'b1;
                    st_reg   <= U_IDLE;
                end
            endcase
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule
`default_nettype wire

// ===== rtl/implicit_diffusion_gauss_seidel_2d.sv =====
// Top level: grid memories, sequencer, configuration registers and result register.
//
//  channel | ports                          | role
//  s_      | s_valid s_ready s_data         | write / read / run requests
//  m_      | m_valid m_ready m_data         | one result per request
//  apb     | psel penable pwrite paddr ...  | coefficient and limit registers
//
// Run: per time step a grid copy to the previous-step memory, then per interior cell
// and sweep the neighbour and cell reads on the single read port, 6 multiply steps,
// 42 divide steps, finish and hand-back; then the 2*(GRID_ROWS+GRID_COLS)-4 border
// cells are zeroed. After reset a clearing pass zeroes both grids; s_ready stays low
// meanwhile. A request is taken while an earlier result waits on m_ready.
`default_nettype none
module implicit_diffusion_gauss_seidel_2d #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire igs_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output igs_pkg::out_item_t     m_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import igs_pkg::*;

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);

    localparam logic [3:0] ST_CLR      = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_WR       = 4'd2;
    localparam logic [3:0] ST_RD       = 4'd3;
    localparam logic [3:0] ST_RDW      = 4'd4;
    localparam logic [3:0] ST_COPY     = 4'd5;
    localparam logic [3:0] ST_SWEEP    = 4'd6;
    localparam logic [3:0] ST_CELL     = 4'd7;
    localparam logic [3:0] ST_WAIT     = 4'd8;
    localparam logic [3:0] ST_SWEND    = 4'd9;
    localparam logic [3:0] ST_BORDER   = 4'd10;
    localparam logic [3:0] ST_STEP_END = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    logic [3:0]         state_reg;
    in_item_t           item_reg;
    logic               inside_reg;
    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      clr_reg;
    logic [AW:0]        cp_reg;
    logic [RW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [2:0]         rcnt_reg;
    logic signed [31:0] up_reg, left_reg, old_reg;
    logic signed [32:0] sx_reg, sy_reg;
    logic [31:0]        largest_reg;
    logic [9:0]         sweeps_reg, steps_reg;
    logic [9:0]         sweeps_next;
    logic               step_ok_reg, all_ok_reg;
    out_item_t          res_reg, out_reg;
    logic               m_valid_reg;

    logic [30:0]        coef_x_reg, coef_y_reg, tol_reg;
    logic [9:0]         max_sweeps_reg, time_steps_reg;

    logic signed [31:0] fmem [CELLS];
    logic signed [31:0] pmem [CELLS];
    logic signed [31:0] f_rdata, p_rdata;
    logic [AW-1:0]      f_raddr, f_waddr, p_waddr;
    logic signed [31:0] f_wdata, p_wdata;
    logic               f_we, p_we;

    logic [AW-1:0]      k_cur;
    logic               in_inside;
    logic [AW-1:0]      in_addr;
    logic signed [32:0] diff;
    logic [31:0]        change;

    cell_req_t          cell_req;
    cell_rsp_t          cell_rsp;

    assign k_cur     = AW'(32'(i_reg) * GRID_COLS + 32'(j_reg));
    assign in_inside = (32'(s_data.row) < GRID_ROWS) && (32'(s_data.col) < GRID_COLS);
    assign in_addr   = in_inside ? AW'(32'(s_data.row) * GRID_COLS + 32'(s_data.col)) : '0;
    assign diff      = {cell_rsp.value[31], cell_rsp.value} - {old_reg[31], old_reg};
    assign change    = diff[32] ? 32'(-diff) : diff[31:0];
    assign sweeps_next = sweeps_reg + 10'd1;

    // ---- grid memories
    always_ff @(posedge aclk) begin
        if (f_we) fmem[f_waddr] <= f_wdata;
        f_rdata <= fmem[f_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_we) pmem[p_waddr] <= p_wdata;
        p_rdata <= pmem[k_cur];
    end

    always_comb begin
        case (state_reg)
            ST_RD:   f_raddr = addr_reg;
            ST_COPY: f_raddr = AW'(cp_reg);
            ST_CELL: begin
                case (rcnt_reg)
                    3'd0:    f_raddr = k_cur - AW'(GRID_COLS);
                    3'd1:    f_raddr = k_cur + AW'(GRID_COLS);
                    3'd2:    f_raddr = k_cur - AW'(1);
                    3'd3:    f_raddr = k_cur + AW'(1);
                    default: f_raddr = k_cur;
                endcase
            end
            default: f_raddr = k_cur;
        endcase
    end

    always_comb begin
        f_we    = 1'b0;
        f_waddr = k_cur;
        f_wdata = '0;
        p_we    = 1'b0;
        p_waddr = AW'(cp_reg - 1'b1);
        p_wdata = f_rdata;
        case (state_reg)
            ST_CLR: begin
                f_we    = 1'b1;
                f_waddr = clr_reg;
                p_we    = 1'b1;
                p_waddr = clr_reg;
                p_wdata = '0;
            end
            ST_WR: begin
                f_we    = inside_reg;
                f_waddr = addr_reg;
                f_wdata = item_reg.cell_value;
            end
            ST_COPY:   p_we = (cp_reg != '0);
            ST_WAIT: begin
                f_we    = cell_rsp.done;
                f_wdata = cell_rsp.value;
            end
            ST_BORDER: f_we = 1'b1;
            default: ;
        endcase
    end

    // ---- update unit
    assign cell_req.start = (state_reg == ST_CELL) && (rcnt_reg == 3'd5);
    assign cell_req.sum_x = sx_reg;
    assign cell_req.sum_y = sy_reg;
    assign cell_req.prev  = p_rdata;

    igs_cell_unit u_cell (
        .aclk    (aclk),
        .aresetn (aresetn),
        .coef_x  (coef_x_reg),
        .coef_y  (coef_y_reg),
        .req     (cell_req),
        .rsp     (cell_rsp)
    );

    // ---- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
                out_reg     <= res_reg;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(CELLS - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg   <= s_data;
                        inside_reg <= in_inside;
                        addr_reg   <= in_addr;
                        // a run with no time steps reports converged straight away
                        res_reg    <= '{read_value: '0, sweeps_used: '0,
                                        converged: (s_data.operation == OP_RUN)
                                                   && (time_steps_reg == '0)};
                        case (s_data.operation)
                            OP_WRITE: state_reg <= ST_WR;
                            OP_READ:  state_reg <= ST_RD;
                            OP_RUN: begin
                                steps_reg  <= '0;
                                sweeps_reg <= '0;
                                all_ok_reg <= 1'b1;
                                cp_reg     <= '0;
                                if (time_steps_reg == '0) begin
                                    state_reg <= ST_DONE;
                                end else begin
                                    state_reg <= ST_COPY;
                                end
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_WR: state_reg <= ST_DONE;
                ST_RD: state_reg <= ST_RDW;
                ST_RDW: begin
                    res_reg.read_value <= inside_reg ? f_rdata : '0;
                    state_reg          <= ST_DONE;
                end
                ST_COPY: begin
                    cp_reg <= cp_reg + 1'b1;
                    if (cp_reg == (AW+1)'(CELLS)) begin
                        sweeps_reg <= '0;
                        if (max_sweeps_reg == '0) begin
                            step_ok_reg <= 1'b0;
                            i_reg       <= '0;
                            j_reg       <= '0;
                            state_reg   <= ST_BORDER;
                        end else begin
                            state_reg <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    largest_reg <= '0;
                    i_reg       <= RW'(1);
                    j_reg       <= CW'(1);
                    rcnt_reg    <= '0;
                    state_reg   <= ST_CELL;
                end
                ST_CELL: begin
                    rcnt_reg <= rcnt_reg + 3'd1;
                    case (rcnt_reg)
                        3'd1: up_reg   <= f_rdata;
                        3'd2: sx_reg   <= {up_reg[31], up_reg} + {f_rdata[31], f_rdata};
                        3'd3: left_reg <= f_rdata;
                        3'd4: sy_reg   <= {left_reg[31], left_reg} + {f_rdata[31], f_rdata};
                        3'd5: begin
                            old_reg   <= f_rdata;
                            state_reg <= ST_WAIT;
                        end
                        default: ;
                    endcase
                end
                ST_WAIT: begin
                    if (cell_rsp.done) begin
                        if (change > largest_reg) largest_reg <= change;
                        rcnt_reg <= '0;
                        if (j_reg == CW'(GRID_COLS - 2)) begin
                            j_reg <= CW'(1);
                            if (i_reg == RW'(GRID_ROWS - 2)) begin
                                state_reg <= ST_SWEND;
                            end else begin
                                i_reg     <= i_reg + 1'b1;
                                state_reg <= ST_CELL;
                            end
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= ST_CELL;
                        end
                    end
                end
                ST_SWEND: begin
                    sweeps_reg <= sweeps_next;
                    i_reg      <= '0;
                    j_reg      <= '0;
                    if (largest_reg < {1'b0, tol_reg}) begin
                        step_ok_reg <= 1'b1;
                        state_reg   <= ST_BORDER;
                    end else if (sweeps_next == max_sweeps_reg) begin
                        step_ok_reg <= 1'b0;
                        state_reg   <= ST_BORDER;
                    end else begin
                        state_reg <= ST_SWEEP;
                    end
                end
                ST_BORDER: begin
                    // top and bottom rows in full, other rows at both ends only
                    if (i_reg == RW'(GRID_ROWS - 1) && j_reg == CW'(GRID_COLS - 1)) begin
                        state_reg <= ST_STEP_END;
                    end else if ((i_reg == '0 || i_reg == RW'(GRID_ROWS - 1))
                                 && j_reg != CW'(GRID_COLS - 1)) begin
                        j_reg <= j_reg + 1'b1;
                    end else if (j_reg == '0) begin
                        j_reg <= CW'(GRID_COLS - 1);
                    end else begin
                        i_reg <= i_reg + 1'b1;
                        j_reg <= '0;
                    end
                end
                ST_STEP_END: begin
                    all_ok_reg <= all_ok_reg & step_ok_reg;
                    steps_reg  <= steps_reg + 10'd1;
                    cp_reg     <= '0;
                    if (steps_reg + 10'd1 == time_steps_reg) begin
                        res_reg   <= '{read_value: '0, sweeps_used: sweeps_reg,
                                       converged: all_ok_reg & step_ok_reg};
                        state_reg <= ST_DONE;
                    end else begin
                        state_reg <= ST_COPY;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ---- configuration port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_x_reg     <= COEF_X_RST;
            coef_y_reg     <= COEF_Y_RST;
            tol_reg        <= TOLERANCE_RST;
            max_sweeps_reg <= MAX_SWEEPS_RST;
            time_steps_reg <= TIME_STEPS_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_COEF_X:     coef_x_reg     <= pwdata[30:0];
                REG_COEF_Y:     coef_y_reg     <= pwdata[30:0];
                REG_TOLERANCE:  tol_reg        <= pwdata[30:0];
                REG_MAX_SWEEPS: max_sweeps_reg <= pwdata[9:0];
                REG_TIME_STEPS: time_steps_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_COEF_X:     prdata = {1'b0, coef_x_reg};
            REG_COEF_Y:     prdata = {1'b0, coef_y_reg};
            REG_TOLERANCE:  prdata = {1'b0, tol_reg};
            REG_MAX_SWEEPS: prdata = {22'b0, max_sweeps_reg};
            REG_TIME_STEPS: prdata = {22'b0, time_steps_reg};
            default:        prdata = '0;
        endcase
    end

    // ---- checks
    a_clr_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_ready)
        else $error("request taken during clearing pass");

    a_unit_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_rsp.done |-> (state_reg == ST_WAIT))
        else $error("cell unit finished while sequencer not waiting");

    a_no_grid_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !f_we)
        else $error("grid written while idle");

    a_sweep_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_STEP_END) |-> (sweeps_reg <= max_sweeps_reg))
        else $error("sweep count beyond limit");

endmodule
`default_nettype wire

// ===== dv/implicit_diffusion_gauss_seidel_2d_tb.sv =====
// Testbench for the implicit 2-D diffusion Gauss-Seidel block: self-checking grid predictor.
`timescale 1ns / 1ps
module implicit_diffusion_gauss_seidel_2d_tb;
    import igs_pkg::*;

    localparam int ROWS = 64;
    localparam int COLS = 64;
    localparam int CELLS = ROWS * COLS;
    localparam int STALL_LIMIT = 1000000;

    class diffusion_scoreboard;
        int            grid[CELLS];
        int            prev_grid[CELLS];
        bit [30:0]     coef_x, coef_y, tol;
        bit [9:0]      sweep_lim, steps;
        out_item_t     pending[$];
        int            errors, checked, writes, reads, runs, conv_runs;

        function new();
            foreach (grid[k]) begin
                grid[k] = 0;
                prev_grid[k] = 0;
            end
            coef_x = COEF_X_RST;
            coef_y = COEF_Y_RST;
            tol = TOLERANCE_RST;
            sweep_lim = MAX_SWEEPS_RST;
            steps = TIME_STEPS_RST;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_COEF_X:     coef_x = v[30:0];
                REG_COEF_Y:     coef_y = v[30:0];
                REG_TOLERANCE:  tol = v[30:0];
                REG_MAX_SWEEPS: sweep_lim = v[9:0];
                REG_TIME_STEPS: steps = v[9:0];
                default: ;
            endcase
        endfunction

        // coefficient times neighbour sum, rounded half away from zero to Q8.24
        function longint weigh(bit [30:0] c, longint s);
            longint unsigned m, p, q;
            m = (s < 0) ? longint'(-s) : s;
            p = longint'(c) * m;
            q = (p + 64'd8388608) >> 24;
            return (s < 0) ? -longint'(q) : longint'(q);
        endfunction

        function int divide(longint num, longint unsigned den);
            longint unsigned m, q, rem, frac, mag;
            m = (num < 0) ? longint'(-num) : num;
            q = m / den;
            rem = m % den;
            frac = ((rem << 25) + den) / (den << 1);
            mag = (q << 24) + frac;
            if (num < 0)
                return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : int'(-longint'(mag));
            return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(mag);
        endfunction

        function bit time_step(output int unsigned swept);
            longint unsigned den, ad, big;
            longint sx, sy, num;
            int nv, k;
            bit done;
            den = 64'd16777216 + 2 * longint'(coef_x) + 2 * longint'(coef_y);
            prev_grid = grid;
            swept = 0;
            done = 0;
            while (swept < sweep_lim && !done) begin
                big = 0;
                for (int i = 1; i < ROWS - 1; i++)
                    for (int j = 1; j < COLS - 1; j++) begin
                        k = i * COLS + j;
                        sx = longint'(grid[k + COLS]) + longint'(grid[k - COLS]);
                        sy = longint'(grid[k + 1]) + longint'(grid[k - 1]);
                        num = longint'(prev_grid[k]) + weigh(coef_x, sx) + weigh(coef_y, sy);
                        nv = divide(num, den);
                        sx = longint'(nv) - longint'(grid[k]);
                        ad = (sx < 0) ? longint'(-sx) : sx;
                        grid[k] = nv;
                        if (ad > big) big = ad;
                    end
                swept++;
                if (big < longint'(tol)) done = 1;
            end
            for (int i = 0; i < ROWS; i++) begin
                grid[i * COLS] = 0;
                grid[i * COLS + COLS - 1] = 0;
            end
            for (int j = 0; j < COLS; j++) begin
                grid[j] = 0;
                grid[(ROWS - 1) * COLS + j] = 0;
            end
            return done;
        endfunction

        function void note_request(in_item_t r);
            out_item_t e;
            int unsigned last;
            bit all;
            e = '0;
            case (r.operation)
                OP_WRITE: begin
                    grid[r.row * COLS + r.col] = r.cell_value;
                    writes++;
                end
                OP_READ: begin
                    e.read_value = grid[r.row * COLS + r.col];
                    reads++;
                end
                OP_RUN: begin
                    all = 1;
                    last = 0;
                    for (int t = 0; t < steps; t++)
                        if (!time_step(last)) all = 0;
                    e.sweeps_used = last[9:0];
                    e.converged = all;
                    runs++;
                    if (all) conv_runs++;
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(out_item_t a);
            out_item_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (a.read_value !== e.read_value) begin
                $display("%0t: read_value exp %h got %h", $time, e.read_value, a.read_value);
                errors++;
            end
            if (a.sweeps_used !== e.sweeps_used) begin
                $display("%0t: sweeps_used exp %0d got %0d", $time, e.sweeps_used,
                         a.sweeps_used);
                errors++;
            end
            if (a.converged !== e.converged) begin
                $display("%0t: converged exp %b got %b", $time, e.converged, a.converged);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    diffusion_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    implicit_diffusion_gauss_seidel_2d uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // result side: check, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     sb.pending.size());
            $display("implicit_diffusion_gauss_seidel_2d test failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, v);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [31:0] cx, logic [31:0] cy, logic [31:0] tl,
                             logic [31:0] ms, logic [31:0] ts);
        reg_write(REG_COEF_X, cx);
        reg_write(REG_COEF_Y, cy);
        reg_write(REG_TOLERANCE, tl);
        reg_write(REG_MAX_SWEEPS, ms);
        reg_write(REG_TIME_STEPS, ts);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic send(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic [31:0] v);
        in_item_t it;
        it.operation = op;
        it.row = r;
        it.col = c;
        it.cell_value = v;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(it);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0300_0000);
            default: return $urandom();
        endcase
    endfunction

    // runs only where the current setting keeps them short
    task automatic random_requests(int n, int run_pct);
        logic [1:0] op;
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(99);
            if (p < run_pct) op = OP_RUN;
            else if (p < run_pct + 5) op = 2'd3;
            else if (p < run_pct + 50) op = OP_WRITE;
            else op = OP_READ;
            if ($urandom_range(199) == 0) drain();
            send(op, 6'($urandom_range(63)), 6'($urandom_range(63)), pick_value());
        end
    endtask

    initial begin
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values, no idling, directed extremes
        configure(32'(COEF_X_RST), 32'(COEF_Y_RST), 32'(TOLERANCE_RST),
                  32'(MAX_SWEEPS_RST), 32'(TIME_STEPS_RST));
        send(OP_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF);
        send(OP_WRITE, 6'd63, 6'd63, 32'h8000_0000);
        send(OP_WRITE, 6'd0, 6'd63, 32'h0100_0000);
        send(OP_WRITE, 6'd63, 6'd0, 32'hFFFF_FFFF);
        send(OP_WRITE, 6'd1, 6'd1, 32'h7FFF_FFFF);
        send(OP_WRITE, 6'd2, 6'd1, 32'h8000_0000);
        send(OP_WRITE, 6'd1, 6'd2, 32'h5A5A_A5A5);
        send(OP_READ, 6'd0, 6'd0, 32'h0);
        send(OP_READ, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send(OP_READ, 6'd0, 6'd63, 32'h0);
        send(OP_READ, 6'd63, 6'd0, 32'h0);
        send(OP_READ, 6'd1, 6'd2, 32'h0);
        send(OP_READ, 6'd30, 6'd30, 32'h0);
        send(2'd3, 6'd63, 6'd63, 32'hFFFF_FFFF);
        send(2'd3, 6'd0, 6'd0, 32'h0);
        random_requests(240, 0);
        drain();

        // largest row weight, no column weight, one sweep that converges
        idle_pct = 64;
        configure(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'd1, 32'd1);
        send(OP_WRITE, 6'd32, 6'd32, 32'h0800_0000);
        send(OP_RUN, 6'd0, 6'd0, 32'h0);
        send(OP_READ, 6'd32, 6'd32, 32'h0);
        send(OP_READ, 6'd0, 6'd0, 32'h0);
        random_requests(240, 0);
        drain();

        // zero tolerance: never converges
        idle_pct = 0;
        stall_pct = 64;
        configure(32'h0, 32'h7FFF_FFFF, 32'h0, 32'd1, 32'd1);
        send(OP_WRITE, 6'd10, 6'd20, 32'h8000_0000);
        send(OP_RUN, 6'd5, 6'd5, 32'h0);
        send(OP_READ, 6'd10, 6'd20, 32'h0);
        send(OP_READ, 6'd10, 6'd21, 32'h0);
        random_requests(240, 0);
        drain();

        // zero sweep limit: steps only copy and clear the border
        idle_pct = 17;
        stall_pct = 17;
        configure($urandom(), $urandom(), $urandom(), 32'd0, 32'd2);
        send(OP_RUN, 6'd0, 6'd0, 32'h0);
        random_requests(250, 5);
        drain();

        // zero time steps: run leaves the grid alone
        idle_pct = 0;
        stall_pct = 0;
        configure($urandom_range(0, 32'h0400_0000), $urandom(), $urandom_range(0, 255),
                  32'd1023, 32'd0);
        send(OP_RUN, 6'd0, 6'd0, 32'h0);
        random_requests(250, 10);
        drain();

        // largest step count, left unexercised by runs
        idle_pct = 17;
        stall_pct = 17;
        configure(32'(COEF_X_RST), 32'(COEF_Y_RST), 32'(TOLERANCE_RST), 32'd1, 32'd1023);
        random_requests(60, 0);
        drain();

        $display("covered %0d cell writes, %0d reads and %0d runs (%0d converged)",
                 sb.writes, sb.reads, sb.runs, sb.conv_runs);
        $display("checked %0d results over six register settings", sb.checked);
        if (sb.errors == 0)
            $display("implicit_diffusion_gauss_seidel_2d test passed");
        else
            $display("implicit_diffusion_gauss_seidel_2d test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/igs_pkg.sv
rtl/igs_cell_unit.sv
rtl/implicit_diffusion_gauss_seidel_2d.sv
dv/implicit_diffusion_gauss_seidel_2d_tb.sv
